/* hdl/valve_pressure_swing_alarm_macros.svh */
`ifndef VALVE_PRESSURE_SWING_ALARM_MACROS_SVH
`define VALVE_PRESSURE_SWING_ALARM_MACROS_SVH

// same-cycle implication
`define VPSA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpsa assertion failed");

// next-cycle implication
`define VPSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpsa assertion failed");

`endif

/* hdl/vpsa_pkg.sv */
package vpsa_pkg;

  localparam int PRESSURE_W  = 16;
  localparam int SWING_W     = PRESSURE_W + 1;
  localparam int DELAY_W     = 16;
  localparam int THRESH_W    = 10;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] PH_OTHER     = 2'd0;
  localparam logic [1:0] PH_INSP_CTRL = 2'd1;
  localparam logic [1:0] PH_INSP_TRIG = 2'd2;
  localparam logic [1:0] PH_EXHALE    = 2'd3;

  localparam logic [1:0] STATUS_IDLE      = 2'd0;
  localparam logic [1:0] STATUS_DETECTED  = 2'd1;
  localparam logic [1:0] STATUS_ACTIVE    = 2'd2;
  localparam logic [1:0] STATUS_DISPLAYED = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_DELAY     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWING_THRESHOLD = 8'd1;

  localparam logic [DELAY_W-1:0]           DELAY_RESET     = 16'd0;
  localparam logic [THRESH_W-1:0]          THRESHOLD_RESET = 10'd10;
  localparam logic signed [PRESSURE_W-1:0] TROUGH_SEED     = 16'sd400;

  typedef enum logic [3:0] {
    ALM_IDLE    = 4'b0001,
    ALM_PENDING = 4'b0010,
    ALM_ACTIVE  = 4'b0100,
    ALM_SHOWN   = 4'b1000
  } vpsa_alarm_t;

  typedef struct packed {
    logic [PRESSURE_W-1:0] pressure;
    logic [1:0]            breath_phase;
    logic                  valve_present;
    logic                  hmi_displayed;
  } vpsa_in_t;

  typedef struct packed {
    logic [1:0] alarm_status;
    logic       start_event;
    logic       end_event;
    logic       priority_flag;
  } vpsa_out_t;

  typedef struct packed {
    logic [DELAY_W-1:0]  alarm_delay;
    logic [THRESH_W-1:0] swing_threshold;
  } vpsa_cfg_t;

  typedef struct packed {
    logic [PRESSURE_W-1:0] peak;
    logic [PRESSURE_W-1:0] trough;
    logic [1:0]            prev_phase;
    vpsa_alarm_t           alarm;
    logic [DELAY_W-1:0]    countdown;
    logic                  priority_bit;
  } vpsa_state_t;

endpackage

/* hdl/vpsa_cfg.sv */
module vpsa_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [vpsa_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [vpsa_pkg::CFG_DATA_W-1:0]     wr_data,
  output vpsa_pkg::vpsa_cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_delay     <= vpsa_pkg::DELAY_RESET;
      cfg.swing_threshold <= vpsa_pkg::THRESHOLD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        vpsa_pkg::CFG_ALARM_DELAY: begin
          cfg.alarm_delay <= wr_data[vpsa_pkg::DELAY_W-1:0];
        end
        vpsa_pkg::CFG_SWING_THRESHOLD: begin
          cfg.swing_threshold <= wr_data[vpsa_pkg::THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/vpsa_step.sv */
module vpsa_step (
  input  vpsa_pkg::vpsa_state_t state,
  input  vpsa_pkg::vpsa_in_t    sample,
  input  vpsa_pkg::vpsa_cfg_t   cfg,
  output vpsa_pkg::vpsa_state_t state_next,
  output vpsa_pkg::vpsa_out_t   result
);

  logic signed [vpsa_pkg::PRESSURE_W-1:0] p;
  logic signed [vpsa_pkg::PRESSURE_W-1:0] peak_old;
  logic signed [vpsa_pkg::PRESSURE_W-1:0] trough_old;
  logic signed [vpsa_pkg::PRESSURE_W-1:0] peak_upd;
  logic signed [vpsa_pkg::PRESSURE_W-1:0] trough_min;
  logic signed [vpsa_pkg::PRESSURE_W-1:0] trough_upd;
  logic signed [vpsa_pkg::SWING_W-1:0]    swing;
  logic signed [vpsa_pkg::SWING_W-1:0]    thr;
  logic                                   in_exh;
  logic                                   was_exh;
  logic                                   in_insp;
  logic                                   low_swing;
  logic                                   high_swing;
  logic [vpsa_pkg::DELAY_W-1:0]           cd_dec;
  vpsa_pkg::vpsa_alarm_t                  alarm_ack;
  vpsa_pkg::vpsa_alarm_t                  alarm_new;
  logic [vpsa_pkg::DELAY_W-1:0]           cd_new;
  logic                                   prio_new;
  logic                                   start_ev;
  logic                                   end_ev;
  logic [1:0]                             status_code;

  assign p          = $signed(sample.pressure);
  assign peak_old   = $signed(state.peak);
  assign trough_old = $signed(state.trough);
  assign in_exh     = (sample.breath_phase == vpsa_pkg::PH_EXHALE);
  assign was_exh    = (state.prev_phase == vpsa_pkg::PH_EXHALE);
  assign in_insp    = (sample.breath_phase == vpsa_pkg::PH_INSP_CTRL) ||
                      (sample.breath_phase == vpsa_pkg::PH_INSP_TRIG);

  assign cd_dec = (state.countdown != '0) ? state.countdown - 1'b1 : state.countdown;
  assign alarm_ack = (state.alarm == vpsa_pkg::ALM_ACTIVE && sample.hmi_displayed) ?
                     vpsa_pkg::ALM_SHOWN : state.alarm;

  assign peak_upd   = (in_insp && (p > peak_old)) ? p : peak_old;
  assign trough_min = (p < trough_old) ? p : trough_old;
  assign trough_upd = !in_exh ? trough_old :
                      (trough_min < 0) ? '0 : trough_min;

  assign swing      = {peak_upd[vpsa_pkg::PRESSURE_W-1], peak_upd} -
                      {trough_upd[vpsa_pkg::PRESSURE_W-1], trough_upd};
  assign thr        = $signed({{(vpsa_pkg::SWING_W - vpsa_pkg::THRESH_W){1'b0}},
                               cfg.swing_threshold});
  assign low_swing  = (swing < thr);
  assign high_swing = (swing > thr);

  always_comb begin
    alarm_new = alarm_ack;
    cd_new    = cd_dec;
    prio_new  = state.priority_bit;
    start_ev  = 1'b0;
    end_ev    = 1'b0;
    case (alarm_ack)
      vpsa_pkg::ALM_IDLE: begin
        if (!in_exh && was_exh && sample.valve_present && low_swing) begin
          alarm_new = vpsa_pkg::ALM_PENDING;
          cd_new    = cfg.alarm_delay;
        end
      end
      vpsa_pkg::ALM_PENDING: begin
        if (high_swing) begin
          alarm_new = vpsa_pkg::ALM_IDLE;
        end else if (cd_dec == '0) begin
          alarm_new = vpsa_pkg::ALM_ACTIVE;
          start_ev  = 1'b1;
          prio_new  = 1'b1;
        end
      end
      vpsa_pkg::ALM_SHOWN: begin
        if (high_swing) begin
          alarm_new = vpsa_pkg::ALM_IDLE;
          prio_new  = 1'b0;
          end_ev    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (alarm_new)
      vpsa_pkg::ALM_IDLE:    status_code = vpsa_pkg::STATUS_IDLE;
      vpsa_pkg::ALM_PENDING: status_code = vpsa_pkg::STATUS_DETECTED;
      vpsa_pkg::ALM_ACTIVE:  status_code = vpsa_pkg::STATUS_ACTIVE;
      vpsa_pkg::ALM_SHOWN:   status_code = vpsa_pkg::STATUS_DISPLAYED;
      default:               status_code = vpsa_pkg::STATUS_IDLE;
    endcase
  end

  // reseed at phase edges, after evaluation
  assign state_next.peak         = (!in_exh && was_exh) ? trough_upd : peak_upd;
  assign state_next.trough       = (in_exh && !was_exh) ? peak_upd : trough_upd;
  assign state_next.prev_phase   = sample.breath_phase;
  assign state_next.alarm        = alarm_new;
  assign state_next.countdown    = cd_new;
  assign state_next.priority_bit = prio_new;

  assign result.alarm_status  = status_code;
  assign result.start_event   = start_ev;
  assign result.end_event     = end_ev;
  assign result.priority_flag = prio_new;

endmodule

/* hdl/valve_pressure_swing_alarm.sv */
// Valve pressure swing alarm. Takes one sample word per clock and returns one status
// word per sample, in order. A sample is captured in an input register, and once the
// output register can take a word a single pass of compare/update logic advances the
// alarm state and loads the result register, from which the status word is offered; a
// new sample can be taken every cycle while the output is not stalled, so the sustained
// rate is one word per clock. Both sides stall cleanly on back-pressure.
// Configuration (index 0 alarm delay, index 1 swing threshold) is always accepted;
// other indexes are ignored.
module valve_pressure_swing_alarm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  vpsa_pkg::vpsa_in_t               sample,
  output logic                             status_valid,
  input  logic                             status_ready,
  output vpsa_pkg::vpsa_out_t              status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [vpsa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vpsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vpsa_pkg::vpsa_cfg_t   cfg;
  vpsa_pkg::vpsa_state_t state;
  vpsa_pkg::vpsa_state_t state_next;
  vpsa_pkg::vpsa_out_t   result;
  vpsa_pkg::vpsa_in_t    hold;
  logic                  hold_valid;
  logic                  advance;

  assign cfg_ready    = 1'b1;
  assign advance      = hold_valid && (!status_valid || status_ready);
  assign sample_ready = !hold_valid || advance;

  vpsa_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vpsa_step u_step (
    .state      (state),
    .sample     (hold),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample_ready) begin
      hold_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      hold <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.peak         <= '0;
      state.trough       <= vpsa_pkg::TROUGH_SEED;
      state.prev_phase   <= vpsa_pkg::PH_OTHER;
      state.alarm        <= vpsa_pkg::ALM_IDLE;
      state.countdown    <= '0;
      state.priority_bit <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (status_ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= result;
    end
  end

endmodule

/* hdl/vpsa_checker.sv */
`include "valve_pressure_swing_alarm_macros.svh"

module vpsa_checker (
  input logic                clk,
  input logic                rst,
  input logic                status_valid,
  input logic                status_ready,
  input vpsa_pkg::vpsa_out_t status
);

  logic out_start;
  logic out_end;
  logic out_raised;
  logic start_ok;
  logic end_ok;

  assign out_start  = status_valid && status.start_event;
  assign out_end    = status_valid && status.end_event;
  assign out_raised = status_valid &&
                      ((status.alarm_status == vpsa_pkg::STATUS_ACTIVE) ||
                       (status.alarm_status == vpsa_pkg::STATUS_DISPLAYED));
  assign start_ok   = (status.alarm_status == vpsa_pkg::STATUS_ACTIVE) && status.priority_flag;
  assign end_ok     = (status.alarm_status == vpsa_pkg::STATUS_IDLE) && !status.priority_flag;

  `VPSA_ASSERT_NOW(a_events_exclusive, clk, rst, out_start, !status.end_event)

  `VPSA_ASSERT_NOW(a_start_is_active, clk, rst, out_start, start_ok)

  `VPSA_ASSERT_NOW(a_end_is_idle, clk, rst, out_end, end_ok)

  `VPSA_ASSERT_NOW(a_raised_has_priority, clk, rst, out_raised, status.priority_flag)

  `VPSA_ASSERT_NEXT(a_stall_holds, clk, rst, status_valid && !status_ready, status_valid && $stable(status))

endmodule

bind valve_pressure_swing_alarm vpsa_checker u_vpsa_checker (.*);
